// ===== hw/rtl/svdbs_pkg.sv =====
`timescale 1ns / 1ps
package svdbs_pkg;

  typedef enum logic [2:0] {
    OP_LOAD_W = 3'd0,
    OP_LOAD_U = 3'd1,
    OP_LOAD_V = 3'd2,
    OP_LOAD_B = 3'd3,
    OP_START  = 3'd4
  } opcode_e;

  localparam logic [2:0] CFG_ROWS_M   = 3'd0;
  localparam logic [2:0] CFG_COLS_N   = 3'd1;
  localparam logic [2:0] CFG_RHS_COLS = 3'd2;
  localparam logic [2:0] CFG_IDENTITY = 3'd3;
  localparam logic [2:0] CFG_EPS      = 3'd4;

  localparam logic signed [47:0] MAX48 = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] MIN48 = 48'sh8000_0000_0000;
  localparam logic signed [31:0] MAX32 = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] MIN32 = 32'sh8000_0000;

  localparam int MUL_SPLIT = 24;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [2:0]         row_index;
    logic [2:0]         col_index;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    logic [2:0]         out_row;
    logic [2:0]         out_col;
    logic signed [31:0] out_value;
    logic               out_last;
  } out_t;

  typedef struct packed {
    logic [3:0]  rows_m;
    logic [3:0]  cols_n;
    logic [3:0]  rhs_cols;
    logic        use_identity_rhs;
    logic [31:0] eps_scaled;
  } cfg_t;

  typedef struct packed {
    opcode_e            kind;
    logic [2:0]         row;
    logic [2:0]         col;
    logic signed [31:0] value;
  } cmd_t;

  function automatic logic signed [47:0] sat48(input logic signed [48:0] v);
    if (v[48] != v[47]) begin
      return v[48] ? MIN48 : MAX48;
    end
    return v[47:0];
  endfunction

  function automatic logic signed [47:0] add48(input logic signed [47:0] a,
                                               input logic signed [47:0] b);
    logic signed [48:0] t;
    t = {a[47], a} + {b[47], b};
    return sat48(t);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    if (!v[47] && (|v[46:31])) begin
      return MAX32;
    end
    if (v[47] && !(&v[46:31])) begin
      return MIN32;
    end
    return v[31:0];
  endfunction

endpackage

// ===== hw/rtl/svdbs_front.sv =====
`timescale 1ns / 1ps
module svdbs_front #(
  parameter int MAX_DIM = 8
) (
  input  logic              in_valid_i,
  input  svdbs_pkg::in_t    in_data_i,
  output logic              in_stall_o,
  input  logic              fifo_full_i,
  output logic              push_o,
  output svdbs_pkg::cmd_t   cmd_o
);

  logic row_ok;
  logic col_ok;
  logic keep;

  assign row_ok = 32'(in_data_i.row_index) < MAX_DIM;
  assign col_ok = 32'(in_data_i.col_index) < MAX_DIM;

  always_comb begin
    keep = 1'b0;
    unique case (in_data_i.opcode) inside
      svdbs_pkg::OP_LOAD_W: keep = row_ok;
      svdbs_pkg::OP_LOAD_U, svdbs_pkg::OP_LOAD_V, svdbs_pkg::OP_LOAD_B: keep = row_ok && col_ok;
      svdbs_pkg::OP_START: keep = 1'b1;
      default: keep = 1'b0;
    endcase
  end

  assign in_stall_o  = fifo_full_i;
  assign push_o      = in_valid_i && !fifo_full_i && keep;
  assign cmd_o.kind  = svdbs_pkg::opcode_e'(in_data_i.opcode);
  assign cmd_o.row   = in_data_i.row_index;
  assign cmd_o.col   = in_data_i.col_index;
  assign cmd_o.value = in_data_i.value;

endmodule

// ===== hw/rtl/svdbs_fifo.sv =====
`timescale 1ns / 1ps
module svdbs_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  svdbs_pkg::cmd_t cmd_i,
  input  logic            pop_i,
  output svdbs_pkg::cmd_t cmd_o,
  output logic            full_o,
  output logic            empty_o
);

  svdbs_pkg::cmd_t slot_q [2];
  logic            wp_q, wp_d;
  logic            rp_q, rp_d;
  logic [1:0]      cnt_q, cnt_d;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign cmd_o   = slot_q[rp_q];

  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wp_d = ~wp_q;
    end
    if (pop_i) begin
      rp_d = ~rp_q;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wp_q] <= cmd_i;
    end
  end

endmodule

// ===== hw/rtl/svdbs_mul.sv =====
`timescale 1ns / 1ps
module svdbs_mul #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               vld_i,
  input  logic signed [47:0] a_i,
  input  logic signed [31:0] b_i,
  output logic               vld_o,
  output logic signed [47:0] p_o
);

  localparam int SPLIT = svdbs_pkg::MUL_SPLIT;
  localparam logic [55:0] PHI_LIM = 56'(1) << (SPLIT - 1 + FRAC_BITS);

  logic        vld1_q, vld2_q, vld3_q, vld4_q;
  logic        neg1_q, neg2_q, neg3_q;
  logic [47:0] ua1_q;
  logic [31:0] ub1_q, ub2_q;
  logic [23:0] lo2_q;
  logic [55:0] phi2_q, phi3_q, plo3_q;
  logic signed [47:0] p_q, p_d;
  logic [57:0] qsum;
  logic [57:0] q;

  always_comb begin
    qsum = (58'(phi3_q) << (SPLIT - FRAC_BITS)) + 58'(plo3_q >> FRAC_BITS);
    q    = (phi3_q >= PHI_LIM) ? (58'(1) << 47) : qsum;
    if (neg3_q) begin
      p_d = (q >= (58'(1) << 47)) ? svdbs_pkg::MIN48 : (~q[47:0] + 48'd1);
    end else begin
      p_d = (q > 58'(svdbs_pkg::MAX48)) ? svdbs_pkg::MAX48 : q[47:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
      vld4_q <= 1'b0;
    end else begin
      vld1_q <= vld_i;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
      vld4_q <= vld3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    neg1_q <= a_i[47] ^ b_i[31];
    ua1_q  <= a_i[47] ? (~a_i + 48'd1) : a_i;
    ub1_q  <= b_i[31] ? (~b_i + 32'd1) : b_i;
    phi2_q <= 56'(ua1_q[47:24]) * 56'(ub1_q);
    lo2_q  <= ua1_q[23:0];
    ub2_q  <= ub1_q;
    neg2_q <= neg1_q;
    plo3_q <= 56'(lo2_q) * 56'(ub2_q);
    phi3_q <= phi2_q;
    neg3_q <= neg2_q;
    p_q    <= p_d;
  end

  assign vld_o = vld4_q;
  assign p_o   = p_q;

endmodule

// ===== hw/rtl/svdbs_engine.sv =====
`timescale 1ns / 1ps
module svdbs_engine #(
  parameter int MAX_DIM   = 8,
  parameter int FRAC_BITS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  svdbs_pkg::cfg_t cfg_i,
  input  logic            cmd_valid_i,
  input  svdbs_pkg::cmd_t cmd_i,
  output logic            cmd_pop_o,
  output logic            busy_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output svdbs_pkg::out_t out_data_o
);

  localparam int CW    = $clog2(MAX_DIM + 1);
  localparam int AW    = $clog2(MAX_DIM);
  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int ADW   = $clog2(DEPTH);
  localparam int QB    = 2 * FRAC_BITS + 1;
  localparam int DCW   = $clog2(QB + 1);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_SUM   = 5'd1;
  localparam logic [4:0] S_THR   = 5'd2;
  localparam logic [4:0] S_CHK   = 5'd3;
  localparam logic [4:0] S_DIV   = 5'd4;
  localparam logic [4:0] S_ROW   = 5'd5;
  localparam logic [4:0] S_RDU   = 5'd6;
  localparam logic [4:0] S_DOT   = 5'd7;
  localparam logic [4:0] S_DOTR  = 5'd8;
  localparam logic [4:0] S_DOTW  = 5'd9;
  localparam logic [4:0] S_SCRW  = 5'd10;
  localparam logic [4:0] S_COL   = 5'd11;
  localparam logic [4:0] S_COLR  = 5'd12;
  localparam logic [4:0] S_COLW  = 5'd13;
  localparam logic [4:0] S_ORD   = 5'd14;
  localparam logic [4:0] S_OUT   = 5'd15;
  localparam logic [4:0] S_OWAIT = 5'd16;

  function automatic logic [CW-1:0] clip_dim(input logic [3:0] v);
    if (v == 4'd0) begin
      return CW'(1);
    end
    if (32'(v) > MAX_DIM) begin
      return CW'(MAX_DIM);
    end
    return CW'(v);
  endfunction

  logic [4:0]          state_q, state_d;
  logic [CW-1:0]       i_q, i_d, j_q, j_d, k_q, k_d;
  logic                kept_q, kept_d;
  logic [DCW-1:0]      dcnt_q, dcnt_d;
  logic                ov_q, ov_d;
  logic signed [31:0]  sum_q, sum_d, thr_q, thr_d, recip_q, recip_d;
  logic signed [47:0]  s_q, s_d;
  logic [32:0]         rem_q, rem_d;
  logic [QB-1:0]       num_q, num_d, quo_q, quo_d;
  logic [31:0]         dabs_q, dabs_d;
  logic                wneg_q, wneg_d;
  svdbs_pkg::out_t     out_q, out_d;

  logic signed [31:0]  w_mem [MAX_DIM];
  logic signed [47:0]  scr_mem [MAX_DIM];
  logic signed [31:0]  u_mem [DEPTH];
  logic signed [31:0]  v_mem [DEPTH];
  logic signed [31:0]  b_mem [DEPTH];
  logic signed [47:0]  acc_mem [DEPTH];
  logic signed [31:0]  u_rd_q, v_rd_q, b_rd_q;
  logic signed [47:0]  acc_rd_q;

  logic [CW-1:0]       m, n, nb, nm;
  logic                ident;
  logic signed [31:0]  w_cur;
  logic signed [64:0]  thr_prod;
  logic [ADW-1:0]      ld_a, u_ra, v_ra, jk_a;
  logic                ld_w, ld_u, ld_v, ld_b;
  logic                scr_we, acc_we;
  logic signed [47:0]  acc_wd;
  logic                mul_vld, mul_done;
  logic signed [47:0]  mul_a, mul_p;
  logic signed [31:0]  mul_b;
  logic [63:0]         q64;

  assign ident    = cfg_i.use_identity_rhs;
  assign m        = clip_dim(cfg_i.rows_m);
  assign n        = clip_dim(cfg_i.cols_n);
  assign nb       = ident ? m : clip_dim(cfg_i.rhs_cols);
  assign nm       = (m < n) ? m : n;
  assign w_cur    = w_mem[i_q[AW-1:0]];
  assign thr_prod = $signed(sum_q) * $signed({1'b0, cfg_i.eps_scaled});
  assign q64      = 64'(quo_q);

  assign ld_a = ADW'(32'(cmd_i.row) * MAX_DIM + 32'(cmd_i.col));
  assign u_ra = ADW'(32'(ident ? k_q : j_q) * MAX_DIM + 32'(i_q));
  assign v_ra = ADW'(32'(j_q) * MAX_DIM + 32'(i_q));
  assign jk_a = ADW'(32'(j_q) * MAX_DIM + 32'(k_q));

  assign ld_w = cmd_pop_o && (cmd_i.kind == svdbs_pkg::OP_LOAD_W);
  assign ld_u = cmd_pop_o && (cmd_i.kind == svdbs_pkg::OP_LOAD_U);
  assign ld_v = cmd_pop_o && (cmd_i.kind == svdbs_pkg::OP_LOAD_V);
  assign ld_b = cmd_pop_o && (cmd_i.kind == svdbs_pkg::OP_LOAD_B);

  svdbs_mul #(
    .FRAC_BITS(FRAC_BITS)
  ) u_mul (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .vld_i (mul_vld),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .vld_o (mul_done),
    .p_o   (mul_p)
  );

  always_comb begin
    logic [32:0]        rem_sh;
    logic signed [32:0] t33;
    state_d   = state_q;
    i_d       = i_q;
    j_d       = j_q;
    k_d       = k_q;
    kept_d    = kept_q;
    dcnt_d    = dcnt_q;
    ov_d      = ov_q;
    sum_d     = sum_q;
    thr_d     = thr_q;
    recip_d   = recip_q;
    s_d       = s_q;
    rem_d     = rem_q;
    num_d     = num_q;
    quo_d     = quo_q;
    dabs_d    = dabs_q;
    wneg_d    = wneg_q;
    out_d     = out_q;
    cmd_pop_o = 1'b0;
    scr_we    = 1'b0;
    acc_we    = 1'b0;
    acc_wd    = mul_p;
    mul_vld   = 1'b0;
    mul_a     = s_q;
    mul_b     = recip_q;
    rem_sh    = {rem_q[31:0], num_q[QB-1]};
    t33       = {sum_q[31], sum_q} + {w_cur[31], w_cur};
    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          if (cmd_i.kind == svdbs_pkg::OP_START) begin
            i_d     = '0;
            sum_d   = '0;
            state_d = S_SUM;
          end
        end
      end
      S_SUM: begin
        if (i_q == nm) begin
          state_d = S_THR;
        end else begin
          if (t33[32] != t33[31]) begin
            sum_d = t33[32] ? svdbs_pkg::MIN32 : svdbs_pkg::MAX32;
          end else begin
            sum_d = t33[31:0];
          end
          i_d = i_q + 1'b1;
        end
      end
      S_THR: begin
        thr_d   = thr_prod[63:32];
        i_d     = '0;
        kept_d  = 1'b0;
        state_d = S_CHK;
      end
      S_CHK: begin
        if (i_q == nm) begin
          j_d     = '0;
          k_d     = '0;
          state_d = S_ORD;
        end else if (w_cur <= thr_q) begin
          i_d = i_q + 1'b1;
        end else if (w_cur == 32'sd0) begin
          recip_d = svdbs_pkg::MAX32;
          k_d     = '0;
          state_d = S_ROW;
        end else begin
          rem_d   = '0;
          num_d   = QB'(1) << (QB - 1);
          quo_d   = '0;
          dcnt_d  = '0;
          dabs_d  = w_cur[31] ? (~w_cur + 32'd1) : w_cur;
          wneg_d  = w_cur[31];
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (dcnt_q == DCW'(QB)) begin
          if (wneg_q) begin
            recip_d = (q64 > 64'h8000_0000) ? svdbs_pkg::MIN32 : (~q64[31:0] + 32'd1);
          end else begin
            recip_d = (q64 > 64'h7FFF_FFFF) ? svdbs_pkg::MAX32 : q64[31:0];
          end
          k_d     = '0;
          state_d = S_ROW;
        end else begin
          if (rem_sh >= {1'b0, dabs_q}) begin
            rem_d = rem_sh - {1'b0, dabs_q};
            quo_d = {quo_q[QB-2:0], 1'b1};
          end else begin
            rem_d = rem_sh;
            quo_d = {quo_q[QB-2:0], 1'b0};
          end
          num_d  = num_q << 1;
          dcnt_d = dcnt_q + 1'b1;
        end
      end
      S_ROW: begin
        if (k_q == nb) begin
          j_d     = '0;
          k_d     = '0;
          state_d = S_COL;
        end else if (ident) begin
          state_d = S_RDU;
        end else begin
          s_d     = '0;
          j_d     = '0;
          state_d = S_DOT;
        end
      end
      S_RDU: begin
        mul_vld = 1'b1;
        mul_a   = 48'(u_rd_q);
        mul_b   = recip_q;
        state_d = S_SCRW;
      end
      S_DOT: begin
        if (j_q == m) begin
          mul_vld = 1'b1;
          mul_a   = s_q;
          mul_b   = recip_q;
          state_d = S_SCRW;
        end else begin
          state_d = S_DOTR;
        end
      end
      S_DOTR: begin
        mul_vld = 1'b1;
        mul_a   = 48'(u_rd_q);
        mul_b   = b_rd_q;
        state_d = S_DOTW;
      end
      S_DOTW: begin
        if (mul_done) begin
          s_d     = svdbs_pkg::add48(s_q, mul_p);
          j_d     = j_q + 1'b1;
          state_d = S_DOT;
        end
      end
      S_SCRW: begin
        if (mul_done) begin
          scr_we  = 1'b1;
          k_d     = k_q + 1'b1;
          state_d = S_ROW;
        end
      end
      S_COL: begin
        state_d = S_COLR;
      end
      S_COLR: begin
        mul_vld = 1'b1;
        mul_a   = scr_mem[k_q[AW-1:0]];
        mul_b   = v_rd_q;
        state_d = S_COLW;
      end
      S_COLW: begin
        if (mul_done) begin
          acc_we = 1'b1;
          acc_wd = kept_q ? svdbs_pkg::add48(acc_rd_q, mul_p) : mul_p;
          if (CW'(k_q + 1'b1) == nb) begin
            k_d = '0;
            if (CW'(j_q + 1'b1) == n) begin
              kept_d  = 1'b1;
              i_d     = i_q + 1'b1;
              state_d = S_CHK;
            end else begin
              j_d     = j_q + 1'b1;
              state_d = S_COL;
            end
          end else begin
            k_d     = k_q + 1'b1;
            state_d = S_COL;
          end
        end
      end
      S_ORD: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        out_d.out_row   = 3'(j_q);
        out_d.out_col   = 3'(k_q);
        out_d.out_value = kept_q ? svdbs_pkg::sat32(acc_rd_q) : 32'sd0;
        out_d.out_last  = (CW'(j_q + 1'b1) == n) && (CW'(k_q + 1'b1) == nb);
        ov_d            = 1'b1;
        state_d         = S_OWAIT;
      end
      S_OWAIT: begin
        if (!out_stall_i) begin
          ov_d = 1'b0;
          if (out_q.out_last) begin
            state_d = S_IDLE;
          end else begin
            if (CW'(k_q + 1'b1) == nb) begin
              k_d = '0;
              j_d = j_q + 1'b1;
            end else begin
              k_d = k_q + 1'b1;
            end
            state_d = S_ORD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      kept_q  <= 1'b0;
      dcnt_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
      kept_q  <= kept_d;
      dcnt_q  <= dcnt_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q   <= sum_d;
    thr_q   <= thr_d;
    recip_q <= recip_d;
    s_q     <= s_d;
    rem_q   <= rem_d;
    num_q   <= num_d;
    quo_q   <= quo_d;
    dabs_q  <= dabs_d;
    wneg_q  <= wneg_d;
    out_q   <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (ld_w) begin
      w_mem[AW'(cmd_i.row)] <= cmd_i.value;
    end
  end

  always_ff @(posedge clk_i) begin
    if (scr_we) begin
      scr_mem[k_q[AW-1:0]] <= mul_p;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_u) begin
      u_mem[ld_a] <= cmd_i.value;
    end
    u_rd_q <= u_mem[u_ra];
  end

  always_ff @(posedge clk_i) begin
    if (ld_v) begin
      v_mem[ld_a] <= cmd_i.value;
    end
    v_rd_q <= v_mem[v_ra];
  end

  always_ff @(posedge clk_i) begin
    if (ld_b) begin
      b_mem[ld_a] <= cmd_i.value;
    end
    b_rd_q <= b_mem[jk_a];
  end

  always_ff @(posedge clk_i) begin
    if (acc_we) begin
      acc_mem[jk_a] <= acc_wd;
    end
    acc_rd_q <= acc_mem[jk_a];
  end

  assign busy_o      = state_q != S_IDLE;
  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;

endmodule

// ===== hw/rtl/svd_back_substitution.sv =====
`timescale 1ns / 1ps
// channel  | signals                               | role
// in       | in_valid_i, in_stall_o, in_data_i     | load and start transactions
// out      | out_valid_o, out_stall_i, out_data_o  | solution elements, row by row
// cfg      | cfg_we_i, cfg_idx_i, cfg_data_i       | register writes, no read-back
//
// The engine takes loads back to back from a two-entry queue while it is idle.
// Start: threshold sum over the first nm singular values, then per kept value a
// bit-serial reciprocal divider (skipped for a zero value) and nb*(m+1) + n*nb
// products through the four-stage multiplier (nb + n*nb in identity mode).
// Output: each element passes the ORD, OUT and OWAIT states, held while stalled.
// No memory clearing after reset.
module svd_back_substitution #(
  parameter int MAX_DIM   = 8,
  parameter int FRAC_BITS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  svdbs_pkg::in_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output svdbs_pkg::out_t out_data_o,
  input  logic            cfg_we_i,
  input  logic [2:0]      cfg_idx_i,
  input  logic [31:0]     cfg_data_i
);

  svdbs_pkg::cfg_t cfg_q, cfg_d;
  logic            fifo_full, fifo_empty, push, pop, eng_busy;
  svdbs_pkg::cmd_t push_cmd, head_cmd;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        svdbs_pkg::CFG_ROWS_M:   cfg_d.rows_m           = cfg_data_i[3:0];
        svdbs_pkg::CFG_COLS_N:   cfg_d.cols_n           = cfg_data_i[3:0];
        svdbs_pkg::CFG_RHS_COLS: cfg_d.rhs_cols         = cfg_data_i[3:0];
        svdbs_pkg::CFG_IDENTITY: cfg_d.use_identity_rhs = cfg_data_i[0];
        svdbs_pkg::CFG_EPS:      cfg_d.eps_scaled       = cfg_data_i;
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rows_m           <= 4'd8;
      cfg_q.cols_n           <= 4'd8;
      cfg_q.rhs_cols         <= 4'd1;
      cfg_q.use_identity_rhs <= 1'b0;
      cfg_q.eps_scaled       <= 32'd5;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  svdbs_front #(
    .MAX_DIM(MAX_DIM)
  ) u_front (
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .fifo_full_i(fifo_full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  svdbs_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .pop_i  (pop),
    .cmd_o  (head_cmd),
    .full_o (fifo_full),
    .empty_o(fifo_empty)
  );

  svdbs_engine #(
    .MAX_DIM  (MAX_DIM),
    .FRAC_BITS(FRAC_BITS)
  ) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .cmd_valid_i(!fifo_empty),
    .cmd_i      (head_cmd),
    .cmd_pop_o  (pop),
    .busy_o     (eng_busy),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  a_out_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i) |=> !out_valid_o)
    else $error("result shown again right after its transaction");

  a_out_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> eng_busy)
    else $error("result valid while engine idle");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !fifo_empty)
    else $error("command popped from empty queue");

endmodule

// ===== verif/svd_back_substitution_tb.sv =====
`timescale 1ns / 1ps
module svd_back_substitution_tb;

  localparam int  DIM       = 8;
  localparam int  FRAC      = 16;
  localparam int  SETTLE    = 40;
  localparam longint LIMIT  = 20000000;
  localparam longint SMAX48 = 64'sd140737488355327;
  localparam longint SMIN48 = -64'sd140737488355328;
  localparam longint SMAX32 = 64'sd2147483647;
  localparam longint SMIN32 = -64'sd2147483648;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_stall;
  svdbs_pkg::in_t  in_data = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  svdbs_pkg::out_t out_data;
  logic            cfg_we = 1'b0;
  logic [2:0]      cfg_idx = '0;
  logic [31:0]     cfg_data = '0;

  svd_back_substitution dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  always #1 clk_i = ~clk_i;

  // predictor state
  logic [3:0]  p_rows, p_cols, p_rhs;
  logic        p_ident;
  logic [31:0] p_eps;
  longint      w_mem[DIM];
  longint      u_mem[DIM*DIM];
  longint      v_mem[DIM*DIM];
  longint      b_mem[DIM*DIM];

  svdbs_pkg::out_t solution_q[$];
  int     mismatches = 0;
  int     tx_idle_pct = 0;
  int     rx_idle_pct = 0;
  int     hold_left = 0;
  longint cycles = 0;

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint qmul(longint a, longint b);
    logic neg;
    longint unsigned ua, ub, phi, plo, q;
    neg = (a < 0) != (b < 0);
    ua = a < 0 ? -a : a;
    ub = b < 0 ? -b : b;
    phi = (ua >> 24) * ub;
    plo = (ua & 64'hFFFFFF) * ub;
    if (phi >= (64'd1 << (23 + FRAC))) q = 64'd1 << 47;
    else q = (phi << (24 - FRAC)) + (plo >> FRAC);
    if (neg) return q >= (64'd1 << 47) ? SMIN48 : -longint'(q);
    return q > SMAX48 ? SMAX48 : longint'(q);
  endfunction

  function automatic int dim_of(logic [3:0] r);
    if (r == 0) return 1;
    return r > DIM ? DIM : int'(r);
  endfunction

  function automatic void solve_expected();
    int m, n, nb, nm;
    longint sum, thr, wi, rc, s;
    longint acc[DIM*DIM];
    longint scr[DIM];
    svdbs_pkg::out_t o;
    m = dim_of(p_rows);
    n = dim_of(p_cols);
    nb = p_ident ? m : dim_of(p_rhs);
    nm = m < n ? m : n;
    sum = 0;
    foreach (acc[a]) acc[a] = 0;
    for (int i = 0; i < nm; i++) sum = clamp(sum + w_mem[i], SMIN32, SMAX32);
    thr = (sum * longint'({32'd0, p_eps})) >>> 32;
    for (int i = 0; i < nm; i++) begin
      wi = w_mem[i];
      if (wi <= thr) continue;
      if (wi == 0) rc = SMAX32;
      else rc = clamp((64'sd1 <<< (2 * FRAC)) / wi, SMIN32, SMAX32);
      for (int k = 0; k < nb; k++) begin
        s = 0;
        if (p_ident) s = u_mem[k*DIM + i];
        else
          for (int j = 0; j < m; j++)
            s = clamp(s + qmul(u_mem[j*DIM + i], b_mem[j*DIM + k]), SMIN48, SMAX48);
        scr[k] = qmul(s, rc);
      end
      for (int j = 0; j < n; j++)
        for (int k = 0; k < nb; k++)
          acc[j*DIM + k] = clamp(acc[j*DIM + k] + qmul(scr[k], v_mem[j*DIM + i]),
                                 SMIN48, SMAX48);
    end
    for (int j = 0; j < n; j++)
      for (int k = 0; k < nb; k++) begin
        o.out_row   = j[2:0];
        o.out_col   = k[2:0];
        o.out_value = 32'(clamp(acc[j*DIM + k], SMIN32, SMAX32));
        o.out_last  = (j == n - 1) && (k == nb - 1);
        solution_q.push_back(o);
      end
  endfunction

  function automatic void apply_item(svdbs_pkg::in_t it);
    int a;
    a = it.row_index * DIM + it.col_index;
    case (it.opcode)
      svdbs_pkg::OP_LOAD_W: w_mem[it.row_index] = longint'(it.value);
      svdbs_pkg::OP_LOAD_U: u_mem[a] = longint'(it.value);
      svdbs_pkg::OP_LOAD_V: v_mem[a] = longint'(it.value);
      svdbs_pkg::OP_LOAD_B: b_mem[a] = longint'(it.value);
      svdbs_pkg::OP_START:  solve_expected();
      default: ;
    endcase
  endfunction

  task automatic send_item(svdbs_pkg::in_t it);
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk_i);
    end
    in_valid = 1'b1;
    in_data = it;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    apply_item(it);
  endtask

  task automatic send(logic [2:0] op, int r, int c, logic [31:0] v);
    svdbs_pkg::in_t it;
    it.opcode = op;
    it.row_index = r[2:0];
    it.col_index = c[2:0];
    it.value = v;
    send_item(it);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid = 1'b0;
    while (solution_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] d);
    @(negedge clk_i);
    in_valid = 1'b0;
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_data = d;
    @(negedge clk_i);
    cfg_we = 1'b0;
    case (idx)
      svdbs_pkg::CFG_ROWS_M:   p_rows = d[3:0];
      svdbs_pkg::CFG_COLS_N:   p_cols = d[3:0];
      svdbs_pkg::CFG_RHS_COLS: p_rhs = d[3:0];
      svdbs_pkg::CFG_IDENTITY: p_ident = d[0];
      svdbs_pkg::CFG_EPS:      p_eps = d;
      default: ;
    endcase
  endtask

  task automatic set_shape(int m, int n, int nb, bit ident, logic [31:0] eps);
    write_reg(svdbs_pkg::CFG_ROWS_M, m);
    write_reg(svdbs_pkg::CFG_COLS_N, n);
    write_reg(svdbs_pkg::CFG_RHS_COLS, nb);
    write_reg(svdbs_pkg::CFG_IDENTITY, {31'd0, ident});
    write_reg(svdbs_pkg::CFG_EPS, eps);
  endtask

  function automatic logic [31:0] rand_elem();
    case ($urandom_range(9))
      0: return $urandom();
      1: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($urandom_range(524288) - 262144);
    endcase
  endfunction

  function automatic logic [31:0] rand_sv();
    case ($urandom_range(9))
      0: return $urandom();
      1: return 32'd0;
      2: return 32'($urandom_range(131072) - 65536);
      default: return $urandom_range(524288, 16384);
    endcase
  endfunction

  function automatic int small_dim();
    case ($urandom_range(9))
      0: return 0;
      1: return $urandom_range(15, 9);
      2: return 8;
      default: return $urandom_range(4, 1);
    endcase
  endfunction

  function automatic logic [31:0] rand_eps();
    case ($urandom_range(4))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom();
      default: return $urandom_range(50000000);
    endcase
  endfunction

  // receiver stall, with optional long hold-off
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall = ($urandom_range(99) < rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    svdbs_pkg::out_t e;
    if (rst_ni && out_valid && !out_stall) begin
      if (solution_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transaction row=%0d col=%0d value=%h last=%b",
                   out_data.out_row, out_data.out_col, out_data.out_value,
                   out_data.out_last);
      end else begin
        e = solution_q.pop_front();
        if (out_data.out_row !== e.out_row || out_data.out_col !== e.out_col ||
            out_data.out_value !== e.out_value || out_data.out_last !== e.out_last) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch exp row=%0d col=%0d value=%h last=%b",
                      " got row=%0d col=%0d value=%h last=%b"},
                     e.out_row, e.out_col, e.out_value, e.out_last,
                     out_data.out_row, out_data.out_col, out_data.out_value,
                     out_data.out_last);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic test_preload();
    for (int r = 0; r < DIM; r++)
      send(svdbs_pkg::OP_LOAD_W, r, $urandom_range(7), rand_sv());
    for (int r = 0; r < DIM; r++)
      for (int c = 0; c < DIM; c++) begin
        send(svdbs_pkg::OP_LOAD_U, r, c, rand_elem());
        send(svdbs_pkg::OP_LOAD_V, r, c, rand_elem());
        send(svdbs_pkg::OP_LOAD_B, r, c, rand_elem());
      end
    send(svdbs_pkg::OP_START, 0, 0, 0);
    wait_idle();
  endtask

  task automatic test_directed();
    set_shape(0, 0, 0, 0, 32'd0);
    send(svdbs_pkg::OP_START, 0, 0, 0);
    wait_idle();
    set_shape(15, 15, 15, 0, 32'd0);
    send(svdbs_pkg::OP_LOAD_W, 0, 0, 32'd1);
    send(svdbs_pkg::OP_LOAD_W, 1, 5, 32'hFFFF_FFFF);
    send(svdbs_pkg::OP_LOAD_U, 0, 0, 32'h7FFF_FFFF);
    send(svdbs_pkg::OP_LOAD_B, 0, 0, 32'h7FFF_FFFF);
    send(svdbs_pkg::OP_LOAD_V, 7, 7, 32'h8000_0000);
    send(svdbs_pkg::OP_START, 0, 0, 0);
    wait_idle();
    // negative sum and full eps: a zero singular value is kept
    set_shape(8, 8, 1, 1, 32'hFFFF_FFFF);
    for (int r = 0; r < DIM; r++)
      send(svdbs_pkg::OP_LOAD_W, r, 0, r == 2 ? 32'd0 : 32'hFFF0_0000);
    send(3'd5, 1, 1, 32'h1234_5678);
    send(3'd6, 2, 2, 32'hFFFF_FFFF);
    send(3'd7, 7, 7, 32'h0);
    send(svdbs_pkg::OP_START, 0, 0, 0);
    wait_idle();
    set_shape(3, 5, 2, 1, 32'd5);
    for (int r = 0; r < DIM; r++) send(svdbs_pkg::OP_LOAD_W, r, 0, rand_sv());
    send(svdbs_pkg::OP_START, 0, 0, 0);
    wait_idle();
  endtask

  task automatic test_random(int items);
    int sent;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(7) == 0) begin
        wait_idle();
        set_shape(small_dim(), small_dim(), small_dim(), $urandom_range(3) == 0,
                  rand_eps());
      end
      repeat ($urandom_range(12)) begin
        case ($urandom_range(9))
          0: send(3'($urandom_range(7, 5)), $urandom_range(7), $urandom_range(7),
                  $urandom());
          1, 2: send(svdbs_pkg::OP_LOAD_W, $urandom_range(7), $urandom_range(7),
                     rand_sv());
          3, 4: send(svdbs_pkg::OP_LOAD_U, $urandom_range(7), $urandom_range(7),
                     rand_elem());
          5, 6: send(svdbs_pkg::OP_LOAD_V, $urandom_range(7), $urandom_range(7),
                     rand_elem());
          default: send(svdbs_pkg::OP_LOAD_B, $urandom_range(7), $urandom_range(7),
                        rand_elem());
        endcase
        sent++;
      end
      send(svdbs_pkg::OP_START, $urandom_range(7), $urandom_range(7), $urandom());
      sent++;
    end
    wait_idle();
  endtask

  task automatic test_backpressure();
    set_shape(2, 2, 2, 0, 32'd0);
    hold_left = 800;
    repeat (6) begin
      send(svdbs_pkg::OP_LOAD_B, $urandom_range(7), $urandom_range(7), rand_elem());
      send(svdbs_pkg::OP_START, 0, 0, 0);
    end
    wait_idle();
  endtask

  initial begin
    p_rows = 4'd8;
    p_cols = 4'd8;
    p_rhs = 4'd1;
    p_ident = 1'b0;
    p_eps = 32'd5;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    tx_idle_pct = 16;
    rx_idle_pct = 67;
    test_preload();
    test_directed();
    test_random(85);
    tx_idle_pct = 67;
    rx_idle_pct = 16;
    test_random(85);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random(85);
    test_backpressure();
    if (mismatches == 0 && solution_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/svdbs_pkg.sv
hw/rtl/svdbs_front.sv
hw/rtl/svdbs_fifo.sv
hw/rtl/svdbs_mul.sv
hw/rtl/svdbs_engine.sv
hw/rtl/svd_back_substitution.sv
verif/svd_back_substitution_tb.sv
